/* hdl/svalloc_pkg.sv */
package svalloc_pkg;

  localparam logic [2:0] REQ_NOTE_ON     = 3'd0;
  localparam logic [2:0] REQ_NOTE_OFF    = 3'd1;
  localparam logic [2:0] REQ_PEDAL       = 3'd2;
  localparam logic [2:0] REQ_ALL_NOTES   = 3'd3;
  localparam logic [2:0] REQ_ALL_SOUND   = 3'd4;
  localparam logic [2:0] REQ_RESET_CTRL  = 3'd5;
  localparam logic [2:0] REQ_VOICE_DONE  = 3'd6;

  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_STOP    = 2'd2;

  localparam logic [1:0] MODE_MONO   = 2'd1;
  localparam logic [1:0] MODE_UNISON = 2'd2;

  localparam logic [1:0] PRIO_LOW  = 2'd1;
  localparam logic [1:0] PRIO_HIGH = 2'd2;

  localparam logic CFG_PLAY_MODE    = 1'b0;
  localparam logic CFG_KEY_PRIORITY = 1'b1;

  typedef struct packed {
    logic               active;
    logic               key_down;
    logic               sustained;
    logic signed [7:0]  note;
    logic [31:0]        order;
  } voice_entry_t;

  typedef struct packed {
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [31:0] order;
  } held_entry_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [2:0]        voice_index;
    logic [6:0]        note_out;
    logic [6:0]        velocity_out;
    logic signed [7:0] glide_from;
    logic              last_command;
  } result_t;

  localparam voice_entry_t VOICE_CLEAR = '{active: 1'b0, key_down: 1'b0, sustained: 1'b0,
                                          note: -8'sd1, order: 32'd0};

endpackage

/* hdl/svalloc_evt_if.sv */
interface svalloc_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [6:0] note_number;
  logic [6:0] velocity;
  logic       from_arp;
  logic       pedal_on;
  logic [2:0] finished_voice;

  modport source (output valid, req_type, note_number, velocity, from_arp, pedal_on,
                  finished_voice, input ready);
  modport sink (input valid, req_type, note_number, velocity, from_arp, pedal_on,
                finished_voice, output ready);
endinterface

/* hdl/svalloc_cmd_if.sv */
interface svalloc_cmd_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [2:0]        voice_index;
  logic [6:0]        note_out;
  logic [6:0]        velocity_out;
  logic signed [7:0] glide_from;
  logic              last_command;

  modport source (output valid, command, voice_index, note_out, velocity_out, glide_from,
                  last_command, input ready);
  modport sink (input valid, command, voice_index, note_out, velocity_out, glide_from,
                last_command, output ready);
endinterface

/* hdl/synth_voice_allocator.sv */
// One request is taken at a time; events.ready is high only while the sequencer is idle.
// The held-note memory and the voice memory are walked one entry at a time, with a read state
// and an examine state per entry. A note on also shifts the held list down when it is full.
// A note off that retriggers in mono or unison mode walks the held list and the voices twice.
// Any cycle in which the command output cannot take a command adds a stall.
// Synchronous active-high reset clears the state, configuration, counters, flags and per-voice valid bits;
// the held-note memory is not cleared.
module synth_voice_allocator #(
  parameter int NUM_VOICES = 8,
  parameter int MAX_HELD   = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [1:0] cfg_data,
  svalloc_evt_if.sink   events,
  svalloc_cmd_if.source commands
);
  import svalloc_pkg::*;

  localparam int VIW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int VCW = $clog2(NUM_VOICES + 1);
  localparam int HIW = $clog2(MAX_HELD);
  localparam int HCW = $clog2(MAX_HELD + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_H_RD, S_H_EX, S_SH_RD, S_SH_EX, S_H_WR, S_P_RD, S_P_EX,
    S_ALLOC, S_V_RD, S_V_EX, S_POLY_STOP, S_POLY_START, S_M_WR, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_POLY, OP_MONO_CLR, OP_MONO_V0, OP_UNI, OP_RELSUS, OP_ANO, OP_ASO,
    OP_SOUND, OP_OFFALL, OP_PMATCH
  } vop_t;

  state_t state;
  vop_t   op;

  logic [1:0] play_mode;
  logic [1:0] key_priority;

  logic [2:0] r_type;
  logic [6:0] r_note;
  logic [6:0] r_vel;
  logic       r_arp;

  logic [HCW-1:0]    held_count;
  logic [31:0]       start_counter;
  logic [31:0]       held_counter;
  logic signed [7:0] last_note;
  logic              pedal_down;

  logic [VCW-1:0] vi;
  logic [HCW-1:0] hi;
  logic [HCW-1:0] hw;

  logic [6:0] anote;
  logic [6:0] avel;

  logic           rel_ok, held_ok;
  logic [VIW-1:0] rel_i, held_i, pick;
  logic [31:0]    rel_o, held_o;
  logic           p_stop;
  logic           sounding;
  logic           found;
  logic [VIW-1:0] m_idx;
  voice_entry_t   m_entry;
  held_entry_t    best;

  voice_entry_t vmem [NUM_VOICES];
  logic [NUM_VOICES-1:0] vvalid;
  voice_entry_t vrd;
  logic         vrd_ok;
  logic           vwe;
  logic [VIW-1:0] vwaddr;
  voice_entry_t   vwdata;

  held_entry_t hmem [MAX_HELD];
  held_entry_t hrd;
  logic           hwe;
  logic [HIW-1:0] hwaddr;
  held_entry_t    hwdata;

  result_t pend;
  logic    pend_v;
  result_t ores;
  logic    ovalid;

  voice_entry_t e;
  logic         keep;
  logic         out_free;
  logic         emit_ok;
  logic         ex_emit;
  result_t      ex_res;
  logic         ex_we;
  logic [VIW-1:0] ex_waddr;
  voice_entry_t ex_wdata;
  logic         go;
  logic         better;
  logic [VIW-1:0] va;
  logic [2:0]     vout;
  logic signed [7:0] vglide;

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[vwaddr] <= vwdata;
    end
    vrd    <= vmem[va];
    vrd_ok <= vvalid[va];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vvalid <= '0;
    end else if (vwe) begin
      vvalid[vwaddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hwe) begin
      hmem[hwaddr] <= hwdata;
    end
    hrd <= hmem[hi[HIW-1:0]];
  end

  always_comb begin
    va       = vi[VIW-1:0];
    vout     = 3'(va);
    e        = vrd_ok ? vrd : VOICE_CLEAR;
    keep     = pedal_down && !r_arp;
    out_free = !ovalid || commands.ready;
    emit_ok  = !pend_v || out_free;
    vglide   = (e.active && !e.note[7]) ? e.note : last_note;
    ex_emit  = 1'b0;
    ex_res   = '{command: CMD_RELEASE, voice_index: vout, note_out: 7'd0,
                 velocity_out: 7'd0, glide_from: -8'sd1, last_command: 1'b0};
    ex_we    = 1'b0;
    ex_waddr = va;
    ex_wdata = e;
    case (state)
      S_V_EX: begin
        case (op)
          OP_MONO_CLR, OP_ASO: begin
            ex_emit = e.active;
            ex_res.command = CMD_STOP;
            ex_we = 1'b1;
            ex_wdata = VOICE_CLEAR;
          end
          OP_MONO_V0, OP_UNI: begin
            ex_emit = 1'b1;
            ex_res.command = CMD_START;
            ex_res.note_out = anote;
            ex_res.velocity_out = avel;
            ex_res.glide_from = vglide;
            ex_we = 1'b1;
            ex_wdata = '{active: 1'b1, key_down: 1'b1, sustained: 1'b0,
                         note: {1'b0, anote}, order: start_counter + 32'd1};
          end
          OP_RELSUS: begin
            if (e.sustained && !e.key_down) begin
              ex_we = 1'b1;
              ex_wdata.sustained = 1'b0;
              ex_emit = e.active;
            end
          end
          OP_ANO: begin
            ex_we = 1'b1;
            if (!e.active) begin
              ex_wdata = VOICE_CLEAR;
            end else begin
              ex_wdata.key_down = 1'b0;
              ex_wdata.sustained = 1'b0;
              ex_emit = 1'b1;
            end
          end
          OP_OFFALL: begin
            if (e.active) begin
              ex_we = 1'b1;
              ex_wdata.key_down = 1'b0;
              ex_wdata.sustained = keep ? 1'b1 : e.sustained;
              ex_emit = !keep;
            end
          end
          default: begin
          end
        endcase
      end
      S_POLY_STOP: begin
        ex_emit = p_stop;
        ex_res.command = CMD_STOP;
        ex_res.voice_index = 3'(pick);
      end
      S_POLY_START: begin
        ex_emit = 1'b1;
        ex_res.command = CMD_START;
        ex_res.voice_index = 3'(pick);
        ex_res.note_out = anote;
        ex_res.velocity_out = avel;
        ex_res.glide_from = last_note;
        ex_we = 1'b1;
        ex_waddr = pick;
        ex_wdata = '{active: 1'b1, key_down: 1'b1, sustained: 1'b0,
                     note: {1'b0, anote}, order: start_counter + 32'd1};
      end
      S_M_WR: begin
        ex_emit = !keep && m_entry.active;
        ex_res.voice_index = 3'(m_idx);
        ex_we = 1'b1;
        ex_waddr = m_idx;
        ex_wdata = m_entry;
        ex_wdata.key_down = 1'b0;
        ex_wdata.sustained = keep ? 1'b1 : m_entry.sustained;
      end
      default: begin
      end
    endcase
    go = !ex_emit || emit_ok;
    case (key_priority)
      PRIO_LOW:  better = hrd.note < best.note;
      PRIO_HIGH: better = hrd.note > best.note;
      default:   better = hrd.order > best.order;
    endcase
  end

  assign events.ready           = (state == S_IDLE);
  assign commands.valid         = ovalid;
  assign commands.command       = ores.command;
  assign commands.voice_index   = ores.voice_index;
  assign commands.note_out      = ores.note_out;
  assign commands.velocity_out  = ores.velocity_out;
  assign commands.glide_from    = ores.glide_from;
  assign commands.last_command  = ores.last_command;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      op            <= OP_POLY;
      play_mode     <= 2'd0;
      key_priority  <= 2'd0;
      held_count    <= '0;
      start_counter <= '0;
      held_counter  <= '0;
      last_note     <= -8'sd1;
      pedal_down    <= 1'b0;
      pend_v        <= 1'b0;
      ovalid        <= 1'b0;
      vwe           <= 1'b0;
      hwe           <= 1'b0;
    end else begin
      vwe <= 1'b0;
      hwe <= 1'b0;
      if (ovalid && commands.ready) begin
        ovalid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_PLAY_MODE:    play_mode <= cfg_data;
          CFG_KEY_PRIORITY: key_priority <= cfg_data;
          default: begin
          end
        endcase
      end
      if (ex_emit && go) begin
        if (pend_v) begin
          ores   <= pend;
          ovalid <= 1'b1;
        end
        pend   <= ex_res;
        pend_v <= 1'b1;
      end
      if (ex_we && go) begin
        vwe    <= 1'b1;
        vwaddr <= ex_waddr;
        vwdata <= ex_wdata;
      end
      case (state)
        S_IDLE: begin
          if (events.valid) begin
            r_type <= events.req_type;
            r_note <= events.note_number;
            r_vel  <= events.velocity;
            r_arp  <= events.from_arp;
            vi     <= '0;
            hi     <= '0;
            hw     <= '0;
            state  <= S_FIN;
            case (events.req_type)
              REQ_NOTE_ON, REQ_NOTE_OFF: state <= S_H_RD;
              REQ_PEDAL: begin
                if (pedal_down != events.pedal_on) begin
                  pedal_down <= events.pedal_on;
                  if (!events.pedal_on) begin
                    op    <= OP_RELSUS;
                    state <= S_V_RD;
                  end
                end
              end
              REQ_ALL_NOTES: begin
                held_count   <= '0;
                held_counter <= '0;
                op           <= OP_ANO;
                state        <= S_V_RD;
              end
              REQ_ALL_SOUND: begin
                held_count    <= '0;
                held_counter  <= '0;
                start_counter <= '0;
                last_note     <= -8'sd1;
                pedal_down    <= 1'b0;
                op            <= OP_ASO;
                state         <= S_V_RD;
              end
              REQ_RESET_CTRL: begin
                pedal_down <= 1'b0;
                op         <= OP_RELSUS;
                state      <= S_V_RD;
              end
              REQ_VOICE_DONE: begin
                if (int'(events.finished_voice) < NUM_VOICES) begin
                  vwe    <= 1'b1;
                  vwaddr <= VIW'(events.finished_voice);
                  vwdata <= VOICE_CLEAR;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_H_RD: begin
          if (hi < held_count) begin
            state <= S_H_EX;
          end else begin
            held_count <= hw;
            if (r_type == REQ_NOTE_ON) begin
              if (hw == HCW'(MAX_HELD)) begin
                hi    <= HCW'(1);
                state <= S_SH_RD;
              end else begin
                state <= S_H_WR;
              end
            end else begin
              vi       <= '0;
              sounding <= 1'b0;
              found    <= 1'b0;
              op       <= (play_mode == MODE_MONO || play_mode == MODE_UNISON) ?
                          OP_SOUND : OP_PMATCH;
              state    <= S_V_RD;
            end
          end
        end
        S_H_EX: begin
          if (hrd.note != r_note) begin
            hwe    <= 1'b1;
            hwaddr <= hw[HIW-1:0];
            hwdata <= hrd;
            hw     <= hw + HCW'(1);
          end
          hi    <= hi + HCW'(1);
          state <= S_H_RD;
        end
        S_SH_RD: begin
          if (hi == HCW'(MAX_HELD)) begin
            held_count <= HCW'(MAX_HELD - 1);
            state      <= S_H_WR;
          end else begin
            state <= S_SH_EX;
          end
        end
        S_SH_EX: begin
          hwe    <= 1'b1;
          hwaddr <= HIW'(hi - HCW'(1));
          hwdata <= hrd;
          hi     <= hi + HCW'(1);
          state  <= S_SH_RD;
        end
        S_H_WR: begin
          hwe          <= 1'b1;
          hwaddr       <= held_count[HIW-1:0];
          hwdata       <= '{note: r_note, vel: r_vel, order: held_counter + 32'd1};
          held_counter <= held_counter + 32'd1;
          held_count   <= held_count + HCW'(1);
          anote        <= r_note;
          avel         <= r_vel;
          state        <= S_ALLOC;
        end
        S_P_RD: begin
          if (hi < held_count) begin
            state <= S_P_EX;
          end else begin
            anote <= best.note;
            avel  <= best.vel;
            state <= S_ALLOC;
          end
        end
        S_P_EX: begin
          if (hi == '0 || better) begin
            best <= hrd;
          end
          hi    <= hi + HCW'(1);
          state <= S_P_RD;
        end
        S_ALLOC: begin
          state   <= S_V_RD;
          rel_ok  <= 1'b0;
          held_ok <= 1'b0;
          if (play_mode == MODE_MONO) begin
            if (NUM_VOICES > 1) begin
              vi <= VCW'(1);
              op <= OP_MONO_CLR;
            end else begin
              vi <= '0;
              op <= OP_MONO_V0;
            end
          end else if (play_mode == MODE_UNISON) begin
            vi <= '0;
            op <= OP_UNI;
          end else begin
            vi <= '0;
            op <= OP_POLY;
          end
        end
        S_V_RD: begin
          if (vi != VCW'(NUM_VOICES)) begin
            state <= S_V_EX;
          end else begin
            state <= S_FIN;
            case (op)
              OP_POLY: begin
                pick   <= rel_ok ? rel_i : (held_ok ? held_i : '0);
                p_stop <= rel_ok || held_ok;
                state  <= S_POLY_STOP;
              end
              OP_MONO_CLR: begin
                vi    <= '0;
                op    <= OP_MONO_V0;
                state <= S_V_RD;
              end
              OP_UNI: last_note <= $signed({1'b0, anote});
              OP_SOUND: begin
                if (sounding) begin
                  if (held_count != '0) begin
                    hi    <= '0;
                    state <= S_P_RD;
                  end else begin
                    vi    <= '0;
                    op    <= OP_OFFALL;
                    state <= S_V_RD;
                  end
                end
              end
              OP_PMATCH: begin
                if (found) begin
                  state <= S_M_WR;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_V_EX: begin
          if (go) begin
            vi    <= vi + VCW'(1);
            state <= S_V_RD;
            case (op)
              OP_POLY: begin
                if (!e.active) begin
                  pick   <= va;
                  p_stop <= 1'b0;
                  state  <= S_POLY_STOP;
                end else if (!e.key_down) begin
                  if (!rel_ok || e.order < rel_o) begin
                    rel_ok <= 1'b1;
                    rel_o  <= e.order;
                    rel_i  <= va;
                  end
                end else if (!held_ok || e.order < held_o) begin
                  held_ok <= 1'b1;
                  held_o  <= e.order;
                  held_i  <= va;
                end
              end
              OP_MONO_V0: begin
                start_counter <= start_counter + 32'd1;
                last_note     <= $signed({1'b0, anote});
                state         <= S_FIN;
              end
              OP_UNI: start_counter <= start_counter + 32'd1;
              OP_SOUND: begin
                if (e.active && e.key_down && e.note == $signed({1'b0, r_note})) begin
                  sounding <= 1'b1;
                end
              end
              OP_PMATCH: begin
                if (e.key_down && e.note == $signed({1'b0, r_note}) &&
                    (!found || e.order < m_entry.order)) begin
                  found   <= 1'b1;
                  m_idx   <= va;
                  m_entry <= e;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_POLY_STOP: begin
          if (go) begin
            state <= S_POLY_START;
          end
        end
        S_POLY_START: begin
          if (go) begin
            start_counter <= start_counter + 32'd1;
            last_note     <= $signed({1'b0, anote});
            state         <= S_FIN;
          end
        end
        S_M_WR: begin
          if (go) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!pend_v) begin
            state <= S_IDLE;
          end else if (out_free) begin
            ores              <= pend;
            ores.last_command <= 1'b1;
            ovalid            <= 1'b1;
            pend_v            <= 1'b0;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_v)
    else $error("result still pending while idle");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= HCW'(MAX_HELD))
    else $error("held count beyond list size");

  a_non_start_fields: assert property (@(posedge clk) disable iff (rst)
    ovalid && ores.command != CMD_START |-> ores.note_out == 7'd0 &&
    ores.velocity_out == 7'd0 && ores.glide_from == -8'sd1)
    else $error("release or stop carries note data");

  a_last_then_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && pend_v && out_free |=> state == S_IDLE && ores.last_command)
    else $error("final command not flagged");

endmodule

/* tb/synth_voice_allocator_tb.sv */
module synth_voice_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import svalloc_pkg::*;

  localparam int NV = 8;
  localparam int NH = 16;
  localparam logic [2:0] REQ_UNKNOWN = 3'd7;
  localparam logic [1:0] MODE_POLY = 2'd0;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [1:0] PRIO_LAST = 2'd0;
  localparam logic [1:0] PRIO_SPARE = 2'd3;

  typedef struct {
    logic [2:0] rq;
    logic [6:0] note;
    logic [6:0] vel;
    logic       arp;
    logic       ped;
    logic [2:0] fin;
    bit         typed;
    result_t    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [1:0] cfg_data = 2'd0;
  int errors = 0;

  svalloc_evt_if ev ();
  svalloc_cmd_if cm ();

  synth_voice_allocator u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .events(ev.sink), .commands(cm.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow state of the allocator.
  logic [1:0]  mode_q, prio_q;
  bit          v_act[NV], v_down[NV], v_sus[NV];
  int          v_note[NV];
  bit [31:0]   v_age[NV];
  bit [6:0]    k_note[NH], k_vel[NH];
  bit [31:0]   k_age[NH];
  int          k_cnt;
  bit [31:0]   start_seq, key_seq;
  int          prev_note;
  bit          pedal_q;
  result_t     cmds_due[$];
  result_t     batch[$];

  function automatic void put_cmd(logic [1:0] c, int v, int n, int vl, int g);
    result_t r;
    r.command = c;
    r.voice_index = v[2:0];
    r.note_out = n[6:0];
    r.velocity_out = vl[6:0];
    r.glide_from = g[7:0];
    r.last_command = 1'b0;
    batch.push_back(r);
  endfunction

  function automatic void wipe_voice(int i);
    v_note[i] = -1;
    v_down[i] = 0;
    v_sus[i] = 0;
    v_age[i] = 0;
  endfunction

  function automatic void kill_voice(int i);
    if (v_act[i]) put_cmd(CMD_STOP, i, 0, 0, -1);
    v_act[i] = 0;
  endfunction

  function automatic void let_go(int i);
    if (v_act[i]) put_cmd(CMD_RELEASE, i, 0, 0, -1);
  endfunction

  function automatic void launch(int i, int n, int vl, int g);
    v_note[i] = n;
    v_down[i] = 1;
    v_sus[i] = 0;
    start_seq = start_seq + 1;
    v_age[i] = start_seq;
    v_act[i] = 1;
    put_cmd(CMD_START, i, n, vl, g);
  endfunction

  function automatic void drop_key(int n);
    int w;
    w = 0;
    for (int i = 0; i < k_cnt && i < NH; i++) begin
      if (k_note[i] == n) continue;
      k_note[w] = k_note[i];
      k_vel[w] = k_vel[i];
      k_age[w] = k_age[i];
      w++;
    end
    k_cnt = w;
  endfunction

  function automatic void add_key(int n, int vl);
    drop_key(n);
    if (k_cnt >= NH) begin
      for (int i = 0; i + 1 < NH; i++) begin
        k_note[i] = k_note[i + 1];
        k_vel[i] = k_vel[i + 1];
        k_age[i] = k_age[i + 1];
      end
      k_cnt = NH - 1;
    end
    k_note[k_cnt] = n;
    k_vel[k_cnt] = vl;
    key_seq = key_seq + 1;
    k_age[k_cnt] = key_seq;
    k_cnt++;
  endfunction

  function automatic int pick_key();
    int b;
    b = 0;
    for (int i = 1; i < k_cnt && i < NH; i++) begin
      if (prio_q == PRIO_LOW) begin
        if (k_note[i] < k_note[b]) b = i;
      end else if (prio_q == PRIO_HIGH) begin
        if (k_note[i] > k_note[b]) b = i;
      end else if (k_age[i] > k_age[b]) begin
        b = i;
      end
    end
    return b;
  endfunction

  function automatic void play_poly(int n, int vl);
    int pick, rel_i, held_i;
    bit rel_ok, held_ok, idle;
    bit [31:0] rel_o, held_o;
    pick = 0; rel_i = 0; held_i = 0;
    rel_ok = 0; held_ok = 0; idle = 0;
    rel_o = 0; held_o = 0;
    for (int i = 0; i < NV; i++) begin
      if (!v_act[i]) begin
        pick = i;
        idle = 1;
        break;
      end
      if (!v_down[i]) begin
        if (!rel_ok || v_age[i] < rel_o) begin
          rel_ok = 1; rel_o = v_age[i]; rel_i = i;
        end
      end else if (!held_ok || v_age[i] < held_o) begin
        held_ok = 1; held_o = v_age[i]; held_i = i;
      end
    end
    if (!idle) pick = rel_ok ? rel_i : (held_ok ? held_i : 0);
    kill_voice(pick);
    launch(pick, n, vl, prev_note);
  endfunction

  function automatic void play_mono(int n, int vl);
    int g;
    for (int i = 1; i < NV; i++) begin
      kill_voice(i);
      wipe_voice(i);
    end
    g = (v_act[0] && v_note[0] >= 0) ? v_note[0] : prev_note;
    launch(0, n, vl, g);
  endfunction

  function automatic void play_unison(int n, int vl);
    int g;
    for (int i = 0; i < NV; i++) begin
      g = (v_act[i] && v_note[i] >= 0) ? v_note[i] : prev_note;
      launch(i, n, vl, g);
    end
  endfunction

  function automatic void free_sustained();
    for (int i = 0; i < NV; i++) begin
      if (!v_sus[i] || v_down[i]) continue;
      v_sus[i] = 0;
      let_go(i);
    end
  endfunction

  function automatic void key_up(int n, bit arp);
    bit keep, sounding, found;
    int h, m;
    bit [31:0] mo;
    keep = pedal_q && !arp;
    drop_key(n);
    if (mode_q == MODE_MONO || mode_q == MODE_UNISON) begin
      sounding = 0;
      for (int i = 0; i < NV; i++)
        if (v_act[i] && v_down[i] && v_note[i] == n) sounding = 1;
      if (!sounding) return;
      if (k_cnt > 0) begin
        h = pick_key();
        if (mode_q == MODE_MONO) play_mono(k_note[h], k_vel[h]);
        else play_unison(k_note[h], k_vel[h]);
        prev_note = k_note[h];
        return;
      end
      for (int i = 0; i < NV; i++) begin
        if (!v_act[i]) continue;
        v_down[i] = 0;
        if (keep) v_sus[i] = 1;
        else let_go(i);
      end
      return;
    end
    found = 0; m = 0; mo = 0;
    for (int i = 0; i < NV; i++) begin
      if (!v_down[i] || v_note[i] != n) continue;
      if (!found || v_age[i] < mo) begin
        found = 1; mo = v_age[i]; m = i;
      end
    end
    if (!found) return;
    v_down[m] = 0;
    if (keep) v_sus[m] = 1;
    else let_go(m);
  endfunction

  function automatic void shadow_reset();
    mode_q = MODE_POLY;
    prio_q = PRIO_LAST;
    for (int i = 0; i < NV; i++) begin
      v_act[i] = 0;
      wipe_voice(i);
    end
    k_cnt = 0;
    start_seq = 0;
    key_seq = 0;
    prev_note = -1;
    pedal_q = 0;
  endfunction

  // Works out the commands one request causes, in order.
  function automatic void predict_commands(stim_row_t r);
    batch.delete();
    case (r.rq)
      REQ_NOTE_ON: begin
        add_key(r.note, r.vel);
        if (mode_q == MODE_MONO) play_mono(r.note, r.vel);
        else if (mode_q == MODE_UNISON) play_unison(r.note, r.vel);
        else play_poly(r.note, r.vel);
        prev_note = r.note;
      end
      REQ_NOTE_OFF: key_up(r.note, r.arp);
      REQ_PEDAL: begin
        if (pedal_q != r.ped) begin
          pedal_q = r.ped;
          if (!r.ped) free_sustained();
        end
      end
      REQ_ALL_NOTES: begin
        k_cnt = 0;
        key_seq = 0;
        for (int i = 0; i < NV; i++) begin
          if (!v_act[i]) begin
            wipe_voice(i);
            continue;
          end
          v_down[i] = 0;
          v_sus[i] = 0;
          let_go(i);
        end
      end
      REQ_ALL_SOUND: begin
        for (int i = 0; i < NV; i++) begin
          kill_voice(i);
          wipe_voice(i);
        end
        k_cnt = 0;
        key_seq = 0;
        start_seq = 0;
        prev_note = -1;
        pedal_q = 0;
      end
      REQ_RESET_CTRL: begin
        pedal_q = 0;
        free_sustained();
      end
      REQ_VOICE_DONE: begin
        if (r.fin < NV) begin
          v_act[r.fin] = 0;
          wipe_voice(r.fin);
        end
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last_command = 1'b1;
  endfunction

  int burst_left = 0;

  task automatic send_request(stim_row_t r);
    if (burst_left == 0) begin
      ev.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    burst_left--;
    ev.valid <= 1'b1;
    ev.req_type <= r.rq;
    ev.note_number <= r.note;
    ev.velocity <= r.vel;
    ev.from_arp <= r.arp;
    ev.pedal_on <= r.ped;
    ev.finished_voice <= r.fin;
    @(posedge clk);
    while (!ev.ready) @(posedge clk);
    predict_commands(r);
    if (r.typed) begin
      cmds_due.push_back(r.want);
    end else begin
      foreach (batch[i]) cmds_due.push_back(batch[i]);
    end
  endtask

  task automatic write_reg(logic idx, logic [1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PLAY_MODE) mode_q = val;
    else prio_q = val;
  endtask

  task automatic wait_idle();
    ev.valid <= 1'b0;
    burst_left = 0;
    while (cmds_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic stim_row_t mk(logic [2:0] rq, int n = 0, int vl = 0, bit a = 0,
                                   bit p = 0, int f = 0);
    stim_row_t r;
    r.rq = rq;
    r.note = n[6:0];
    r.vel = vl[6:0];
    r.arp = a;
    r.ped = p;
    r.fin = f[2:0];
    r.typed = 0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t mk_typed(stim_row_t r, logic [1:0] c, int v, int n, int vl,
                                         int g);
    r.typed = 1;
    r.want = '{command: c, voice_index: v[2:0], note_out: n[6:0], velocity_out: vl[6:0],
               glide_from: g[7:0], last_command: 1'b1};
    return r;
  endfunction

  function automatic stim_row_t random_request();
    int k, n;
    k = $urandom_range(0, 99);
    n = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 127) : $urandom_range(40, 63);
    if (k < 45) return mk(REQ_NOTE_ON, n, $urandom_range(0, 127));
    if (k < 75) return mk(REQ_NOTE_OFF, n, $urandom_range(0, 127), $urandom_range(0, 3) == 0);
    if (k < 84) return mk(REQ_PEDAL, n, 0, 0, $urandom_range(0, 1));
    if (k < 91) return mk(REQ_VOICE_DONE, 0, 0, 0, 0, $urandom_range(0, 7));
    if (k < 93) return mk(REQ_ALL_NOTES, n);
    if (k < 95) return mk(REQ_ALL_SOUND);
    if (k < 98) return mk(REQ_RESET_CTRL, 0, 0, $urandom_range(0, 1), $urandom_range(0, 1));
    return mk(REQ_UNKNOWN, n, $urandom_range(0, 127), $urandom_range(0, 1),
              $urandom_range(0, 1), $urandom_range(0, 7));
  endfunction

  // The receiver steps through four stall habits in turn.
  int rx_cycle = 0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 200) % 4)
      0: cm.ready <= 1'b1;
      1: cm.ready <= $urandom_range(0, 1);
      2: cm.ready <= (rx_cycle % 4) == 0;
      default: cm.ready <= (rx_cycle % 16) < 9;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && cm.valid && cm.ready) begin
      if (cmds_due.size() == 0) begin
        $display("%0t: unexpected command, expected none, actual %p", $time,
                 result_t'{cm.command, cm.voice_index, cm.note_out, cm.velocity_out,
                           cm.glide_from, cm.last_command});
        errors++;
      end else begin
        result_t e;
        result_t g;
        e = cmds_due.pop_front();
        g = '{cm.command, cm.voice_index, cm.note_out, cm.velocity_out, cm.glide_from,
              cm.last_command};
        if (g !== e) begin
          $display("%0t: command mismatch, expected %p, actual %p", $time, e, g);
          errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    logic [1:0] modes[8] = '{MODE_MONO, MODE_UNISON, MODE_SPARE, MODE_POLY, MODE_MONO,
                             MODE_UNISON, MODE_MONO, MODE_POLY};
    logic [1:0] prios[8] = '{PRIO_LOW, PRIO_HIGH, PRIO_SPARE, PRIO_HIGH, PRIO_HIGH,
                             PRIO_LAST, PRIO_SPARE, PRIO_LOW};
    ev.valid = 1'b0;
    ev.req_type = REQ_NOTE_ON;
    ev.note_number = '0;
    ev.velocity = '0;
    ev.from_arp = 1'b0;
    ev.pedal_on = 1'b0;
    ev.finished_voice = '0;
    shadow_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(CFG_PLAY_MODE, MODE_POLY);
    write_reg(CFG_KEY_PRIORITY, PRIO_LAST);

    rows.push_back(mk_typed(mk(REQ_NOTE_ON, 0, 0), CMD_START, 0, 0, 0, -1));
    rows.push_back(mk_typed(mk(REQ_NOTE_ON, 127, 127), CMD_START, 1, 127, 127, 0));
    rows.push_back(mk_typed(mk(REQ_NOTE_OFF, 127), CMD_RELEASE, 1, 0, 0, -1));
    rows.push_back(mk(REQ_UNKNOWN, 127, 127, 1, 1, 7));
    rows.push_back(mk(REQ_PEDAL, 0, 0, 0, 1));
    rows.push_back(mk(REQ_PEDAL, 0, 0, 0, 1));
    rows.push_back(mk(REQ_NOTE_OFF, 0));
    rows.push_back(mk_typed(mk(REQ_PEDAL, 0, 0, 0, 0), CMD_RELEASE, 0, 0, 0, -1));
    rows.push_back(mk(REQ_NOTE_ON, 60, 100));
    rows.push_back(mk(REQ_PEDAL, 0, 0, 0, 1));
    rows.push_back(mk(REQ_NOTE_OFF, 60, 0, 1));
    rows.push_back(mk(REQ_RESET_CTRL));
    rows.push_back(mk(REQ_VOICE_DONE, 0, 0, 0, 0, 7));
    rows.push_back(mk(REQ_VOICE_DONE, 0, 0, 0, 0, 0));
    for (int i = 0; i < 9; i++) rows.push_back(mk(REQ_NOTE_ON, 10 + i, 1 + i * 15));
    rows.push_back(mk(REQ_NOTE_ON, 12, 77));
    rows.push_back(mk(REQ_ALL_NOTES));
    rows.push_back(mk(REQ_ALL_SOUND));
    foreach (rows[i]) send_request(rows[i]);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      write_reg(CFG_PLAY_MODE, modes[ph]);
      write_reg(CFG_KEY_PRIORITY, prios[ph]);
      for (int i = 0; i < 38; i++) send_request(random_request());
    end

    wait_idle();
    if (errors == 0 && cmds_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
hdl/svalloc_pkg.sv
hdl/svalloc_evt_if.sv
hdl/svalloc_cmd_if.sv
hdl/synth_voice_allocator.sv
tb/synth_voice_allocator_tb.sv
